// ===== rtl/fbfl_pkg.sv =====
package fbfl_pkg;

  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned LinkW     = IdxW + 1;
  localparam int unsigned CountW    = 9;
  localparam int unsigned BytesW    = 13;
  localparam int unsigned OffsetW   = 20;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [LinkW-1:0]  NullLink    = LinkW'(MaxBlocks);
  localparam logic [CountW-1:0] CountReset  = CountW'(256);
  localparam logic [CountW-1:0] CountLimit  = CountW'(256);
  localparam logic [BytesW-1:0] BytesReset  = BytesW'(8);
  localparam logic [BytesW-1:0] BytesLimit  = BytesW'(4096);
  localparam logic [BytesW-1:0] AlignMask   = BytesW'(8 - 1);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic {
    CFG_BLOCK_COUNT = 1'b0,
    CFG_BLOCK_BYTES = 1'b1
  } cfg_index_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  typedef struct packed {
    logic             rd_en;
    logic [IdxW-1:0]  rd_addr;
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    logic [LinkW-1:0] wr_data;
    logic             clear;
  } link_req_t;

endpackage

// ===== rtl/fixed_block_free_list_allocator.sv =====
// Fixed-size block pool kept as a LIFO free list. Pulse start_i while busy_o is low with
// opcode_i = 0 to allocate (pop the head) or 1 to free free_index_i (push). Each command
// first reads the link at the head from the synchronous link memory, then updates the
// head and the link. The result (status, block index and byte offset = index times the
// block size rounded up to 8 bytes) appears on the result ports for exactly one cycle,
// marked by result_valid_o, registered from the execute state; it cannot be held off,
// so capture it then. A new command is not taken while busy_o is high, so each command
// finishes before the next is accepted. Configuration writes are taken while busy_o and
// start_i are both low, so a command wins over a write in the same cycle; any write
// rebuilds the free list with every block free, at once and without a clearing pass.
module fixed_block_free_list_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            opcode_i,
  input  logic [fbfl_pkg::IdxW-1:0]       free_index_i,
  output logic                            result_valid_o,
  output logic [1:0]                      status_o,
  output logic [fbfl_pkg::IdxW-1:0]       block_index_o,
  output logic [fbfl_pkg::OffsetW-1:0]    byte_offset_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [fbfl_pkg::CfgDataW-1:0]   cfg_data_i
);
  import fbfl_pkg::*;

  fsm_e               state_q, state_d;
  logic [LinkW-1:0]   head_q, head_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [BytesW-1:0]  size_q, size_d;
  opcode_e            op_q;
  logic [IdxW-1:0]    idx_q;
  logic               accept, cfg_write;
  link_req_t          link_req;
  logic [LinkW-1:0]   link_rd;
  logic [CountW-1:0]  cfg_count;
  logic [BytesW-1:0]  cfg_bytes;
  status_e            status_d;
  logic [IdxW-1:0]    blk_d;
  logic               res_valid_q;
  status_e            status_q;
  logic [IdxW-1:0]    blk_q;
  logic [OffsetW-1:0] off_q;
  logic [IdxW+BytesW-1:0] product;

  assign busy_o      = (state_q == FSM_EXEC);
  assign cfg_ready_o = (state_q == FSM_IDLE) && !start_i;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign accept      = start_i && !busy_o;

  fbfl_link_store u_link_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (link_req),
    .count_i   (count_q),
    .rd_data_o (link_rd)
  );

  always_comb begin
    cfg_count = cfg_data_i[CountW-1:0];
    if (cfg_count == '0) begin
      cfg_count = CountW'(1);
    end else if (cfg_count > CountLimit) begin
      cfg_count = CountLimit;
    end
    cfg_bytes = cfg_data_i[BytesW-1:0];
    if (cfg_bytes == '0) begin
      cfg_bytes = BytesW'(1);
    end else if (cfg_bytes > BytesLimit) begin
      cfg_bytes = BytesLimit;
    end
    cfg_bytes = (cfg_bytes + AlignMask) & ~AlignMask;
  end

  always_comb begin
    state_d          = state_q;
    head_d           = head_q;
    count_d          = count_q;
    size_d           = size_q;
    status_d         = ST_OK;
    blk_d            = '0;
    link_req         = '0;
    link_req.rd_addr = head_q[IdxW-1:0];
    link_req.wr_addr = idx_q;
    link_req.wr_data = head_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (cfg_write) begin
          unique case (cfg_index_e'(cfg_index_i))
            CFG_BLOCK_COUNT: count_d = cfg_count;
            CFG_BLOCK_BYTES: size_d  = cfg_bytes;
            default: ;
          endcase
          head_d         = '0;
          link_req.clear = 1'b1;
        end else if (accept) begin
          link_req.rd_en = 1'b1;
          state_d        = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        state_d = FSM_IDLE;
        if (op_q == OP_ALLOC) begin
          if (head_q[IdxW] || (head_q >= LinkW'(count_q))) begin
            status_d = ST_EMPTY;
          end else begin
            blk_d  = head_q[IdxW-1:0];
            head_d = link_rd;
          end
        end else begin
          blk_d = idx_q;
          if (CountW'(idx_q) >= count_q) begin
            status_d = ST_BAD_INDEX;
          end else begin
            link_req.wr_en = 1'b1;
            head_d         = LinkW'(idx_q);
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  assign product = blk_d * size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      head_q      <= '0;
      count_q     <= CountReset;
      size_q      <= BytesReset;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      size_q      <= size_d;
      res_valid_q <= (state_q == FSM_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_e'(opcode_i);
      idx_q <= free_index_i;
    end
    if (state_q == FSM_EXEC) begin
      status_q <= status_d;
      blk_q    <= blk_d;
      off_q    <= (status_d == ST_OK) ? product[OffsetW-1:0] : '0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign block_index_o  = blk_q;
  assign byte_offset_o  = off_q;

endmodule

// ===== rtl/fbfl_link_store.sv =====
module fbfl_link_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fbfl_pkg::link_req_t       req_i,
  input  logic [fbfl_pkg::CountW-1:0] count_i,
  output logic [fbfl_pkg::LinkW-1:0]  rd_data_o
);
  import fbfl_pkg::*;

  logic [LinkW-1:0]     mem_q [MaxBlocks];
  logic [MaxBlocks-1:0] valid_q;
  logic [LinkW-1:0]     mem_rd_q;
  logic                 rd_valid_q;
  logic [IdxW-1:0]      rd_addr_q;
  logic [LinkW-1:0]     chain_link;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      mem_rd_q  <= mem_q[req_i.rd_addr];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr] && !req_i.clear;
      end
    end
  end

  // untouched entries read as the rebuilt chain
  always_comb begin
    if ((LinkW'(rd_addr_q) + LinkW'(1)) < LinkW'(count_i)) begin
      chain_link = LinkW'(rd_addr_q) + LinkW'(1);
    end else begin
      chain_link = NullLink;
    end
    rd_data_o = rd_valid_q ? mem_rd_q : chain_link;
  end

endmodule

// ===== bench/tb_fixed_block_free_list_allocator.sv =====
`timescale 1ns / 1ps

module tb_fixed_block_free_list_allocator;
  import fbfl_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned ItemsPerPhase = 400;
  localparam logic RowCmd = 1'b0;
  localparam logic RowCfg = 1'b1;

  typedef struct packed {
    status_e            status;
    logic [IdxW-1:0]    index;
    logic [OffsetW-1:0] offset;
  } pool_reply_t;

  // cmd rows: sel is the opcode, arg the free index; cfg rows: sel is the register, arg the data
  typedef struct packed {
    logic                kind;
    logic                sel;
    logic [CfgDataW-1:0] arg;
    logic                pinned;
    pool_reply_t         reply;
  } plan_row_t;

  localparam plan_row_t Plan [34] = '{
    '{RowCmd, OP_ALLOC, 13'd0, 1'b1, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b1, '{ST_OK, 8'd1, 20'd8}},
    '{RowCmd, OP_FREE, 13'd255, 1'b1, '{ST_OK, 8'd255, 20'd2040}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b1, '{ST_OK, 8'd255, 20'd2040}},
    '{RowCmd, OP_FREE, 13'd0, 1'b1, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_FREE, 13'd0, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCfg, CFG_BLOCK_COUNT, 13'd1, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b1, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b1, '{ST_EMPTY, 8'd0, 20'd0}},
    '{RowCmd, OP_FREE, 13'd1, 1'b1, '{ST_BAD_INDEX, 8'd1, 20'd0}},
    '{RowCmd, OP_FREE, 13'd255, 1'b1, '{ST_BAD_INDEX, 8'd255, 20'd0}},
    '{RowCmd, OP_FREE, 13'd0, 1'b1, '{ST_OK, 8'd0, 20'd0}},
    '{RowCfg, CFG_BLOCK_BYTES, 13'd4096, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCfg, CFG_BLOCK_COUNT, 13'd256, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_FREE, 13'd255, 1'b1, '{ST_OK, 8'd255, 20'd1044480}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b1, '{ST_OK, 8'd255, 20'd1044480}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b1, '{ST_OK, 8'd0, 20'd0}},
    '{RowCfg, CFG_BLOCK_BYTES, 13'd0, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_FREE, 13'd170, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCfg, CFG_BLOCK_BYTES, 13'd8191, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_FREE, 13'd85, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCfg, CFG_BLOCK_COUNT, 13'd0, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b1, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b1, '{ST_EMPTY, 8'd0, 20'd0}},
    '{RowCfg, CFG_BLOCK_COUNT, 13'd8191, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCfg, CFG_BLOCK_BYTES, 13'd13, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCfg, CFG_BLOCK_COUNT, 13'd2, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_FREE, 13'd2, 1'b1, '{ST_BAD_INDEX, 8'd2, 20'd0}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b0, '{ST_OK, 8'd0, 20'd0}},
    '{RowCmd, OP_ALLOC, 13'd0, 1'b1, '{ST_EMPTY, 8'd0, 20'd0}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic                opcode_i = OP_ALLOC;
  logic [IdxW-1:0]     free_index_i = '0;
  logic                result_valid_o;
  logic [1:0]          status_o;
  logic [IdxW-1:0]     block_index_o;
  logic [OffsetW-1:0]  byte_offset_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i = CFG_BLOCK_COUNT;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic                pin_valid = 1'b0;
  pool_reply_t         pin_reply = '0;

  logic [LinkW-1:0]    link_mem [MaxBlocks];
  logic [LinkW-1:0]    head_ptr;
  logic [CountW-1:0]   count_reg;
  logic [BytesW-1:0]   bytes_reg;

  pool_reply_t         awaited_replies [$];
  logic [IdxW-1:0]     handed_out [$];
  int unsigned         taken_cmds = 0;
  int unsigned         taken_writes = 0;
  int unsigned         mismatches = 0;
  int unsigned         cycles = 0;
  int unsigned         idle_pct = 0;

  fixed_block_free_list_allocator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .free_index_i   (free_index_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .block_index_o  (block_index_o),
    .byte_offset_o  (byte_offset_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pool_blocks();
    int unsigned c;
    c = count_reg;
    if (c < 1) c = 1;
    if (c > CountLimit) c = CountLimit;
    if (c > MaxBlocks) c = MaxBlocks;
    return c;
  endfunction

  function automatic int unsigned slot_bytes();
    int unsigned b;
    b = bytes_reg;
    if (b < 1) b = 1;
    if (b > BytesLimit) b = BytesLimit;
    return (b + AlignMask) & ~32'(AlignMask);
  endfunction

  function automatic void rebuild_pool();
    for (int i = 0; i < MaxBlocks; i++) begin
      link_mem[i] = (i + 1 < pool_blocks()) ? LinkW'(i + 1) : NullLink;
    end
    head_ptr = '0;
  endfunction

  function automatic pool_reply_t pool_apply(opcode_e op, logic [IdxW-1:0] idx);
    pool_reply_t r;
    r = '{ST_OK, '0, '0};
    if (op == OP_ALLOC) begin
      if (head_ptr >= NullLink || head_ptr >= pool_blocks()) begin
        r.status = ST_EMPTY;
      end else begin
        r.index = head_ptr[IdxW-1:0];
        head_ptr = link_mem[r.index];
        r.offset = OffsetW'(r.index * slot_bytes());
        handed_out.push_back(r.index);
      end
    end else if (idx >= pool_blocks()) begin
      r.status = ST_BAD_INDEX;
      r.index = idx;
    end else begin
      link_mem[idx] = head_ptr;
      head_ptr = LinkW'(idx);
      r.index = idx;
      r.offset = OffsetW'(idx * slot_bytes());
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input pool_reply_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: want st=%0d idx=%0d off=%0d, got st=%0d idx=%0d off=%0d",
               $time, what, want.status, want.index, want.offset,
               status_o, block_index_o, byte_offset_o);
    end
  endtask

  // sampled mid-cycle: the values here are the ones seen at the next rising edge
  always @(negedge clk_i) begin
    pool_reply_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o === 1'b1) begin
        if (cfg_index_i == CFG_BLOCK_COUNT) count_reg = cfg_data_i[CountW-1:0];
        else bytes_reg = cfg_data_i[BytesW-1:0];
        rebuild_pool();
        handed_out.delete();
        taken_writes++;
      end
      if (result_valid_o === 1'b1) begin
        if (awaited_replies.size() == 0) begin
          flag_mismatch("result with no transaction pending", '0);
        end else begin
          want = awaited_replies.pop_front();
          if (status_o !== want.status || block_index_o !== want.index ||
              byte_offset_o !== want.offset) begin
            flag_mismatch("result mismatch", want);
          end
        end
      end
      if (start_i && busy_o === 1'b0) begin
        want = pool_apply(opcode_e'(opcode_i), free_index_i);
        awaited_replies.push_back(pin_valid ? pin_reply : want);
        taken_cmds++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic issue(input opcode_e op, input logic [IdxW-1:0] idx,
                       input logic pinned, input pool_reply_t want);
    int unsigned seen;
    cfg_valid_i <= 1'b0;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    seen = taken_cmds;
    start_i      <= 1'b1;
    opcode_i     <= op;
    free_index_i <= idx;
    pin_valid    <= pinned;
    pin_reply    <= want;
    do @(posedge clk_i); while (taken_cmds == seen);
  endtask

  task automatic write_reg(input cfg_index_e which, input logic [CfgDataW-1:0] value);
    int unsigned seen;
    seen = taken_writes;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (taken_writes == seen);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned seg;
    int unsigned roll;
    int unsigned which;
    int          pos;
    logic [IdxW-1:0]     idx;
    logic [CfgDataW-1:0] value;

    count_reg = CountReset;
    bytes_reg = BytesReset;
    rebuild_pool();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 31;
    for (int r = 0; r < $size(Plan); r++) begin
      if (Plan[r].kind == RowCfg) begin
        settle();
        write_reg(cfg_index_e'(Plan[r].sel), Plan[r].arg);
      end else begin
        issue(opcode_e'(Plan[r].sel), Plan[r].arg[IdxW-1:0], Plan[r].pinned, Plan[r].reply);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 31 : (ph == 1) ? 79 : 0;
      sent = 0;
      while (sent < ItemsPerPhase) begin
        settle();
        which = $urandom_range(2);
        if (which != 1) begin
          case ($urandom_range(7))
            0: value = 1;
            1: value = 2;
            2: value = 256;
            3: value = 0;
            4: value = CfgDataW'($urandom_range(8191, 257));
            5: value = CfgDataW'($urandom_range(256, 3));
            default: value = CfgDataW'($urandom_range(24, 3));
          endcase
          write_reg(CFG_BLOCK_COUNT, value);
        end
        if (which != 0) begin
          case ($urandom_range(5))
            0: value = 1;
            1: value = 4096;
            2: value = 0;
            3: value = CfgDataW'($urandom_range(8191, 4097));
            default: value = CfgDataW'($urandom_range(4096, 1));
          endcase
          write_reg(CFG_BLOCK_BYTES, value);
        end
        seg = $urandom_range(80, 20);
        repeat (seg) begin
          roll = $urandom_range(99);
          if (roll < 12) begin
            // noise: bad index or a double free
            issue(OP_FREE, IdxW'($urandom_range(255)), 1'b0, '0);
          end else if (roll < 50 && handed_out.size() != 0) begin
            pos = $urandom_range(handed_out.size() - 1);
            idx = handed_out[pos];
            handed_out.delete(pos);
            issue(OP_FREE, idx, 1'b0, '0);
          end else begin
            issue(OP_ALLOC, IdxW'($urandom_range(255)), 1'b0, '0);
          end
          sent++;
        end
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fbfl_pkg.sv
rtl/fbfl_link_store.sv
rtl/fixed_block_free_list_allocator.sv
bench/tb_fixed_block_free_list_allocator.sv
